// ===== rtl/lzd_pkg.sv =====
`timescale 1ns / 1ps
package lzd_pkg;

  // history size and derived address width
  localparam int unsigned HISTORY_DEPTH = 65536;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);

  // saturation limit of the produced length
  localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

  // mode codes (mode word divided by two)
  localparam logic [2:0] MODE_ABS    = 3'd0;
  localparam logic [2:0] MODE_CTRL10 = 3'd1;
  localparam logic [2:0] MODE_CTRL11 = 3'd2;
  localparam logic [2:0] MODE_FLAG13 = 3'd3;
  localparam logic [2:0] MODE_FLAG12 = 3'd4;
  localparam logic [2:0] MODE_STORED = 3'd5;

  // largest legal mode word
  localparam logic [15:0] MODE_WORD_MAX = 16'd10;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_MODE = 1'b1;

  // parser phase, one-hot
  typedef enum logic [12:0] {
    PH_HDR0    = 13'b0000000000001,
    PH_HDR1    = 13'b0000000000010,
    PH_HDR2    = 13'b0000000000100,
    PH_HDR3    = 13'b0000000001000,
    PH_CTRL    = 13'b0000000010000,
    PH_OFS_LO  = 13'b0000000100000,
    PH_OFS_HI  = 13'b0000001000000,
    PH_DIST    = 13'b0000010000000,
    PH_LIT     = 13'b0000100000000,
    PH_FLAG    = 13'b0001000000000,
    PH_ITEM    = 13'b0010000000000,
    PH_PAIR2   = 13'b0100000000000,
    PH_STORED  = 13'b1000000000000
  } phase_e;

endpackage

// ===== rtl/lzd_ram.sv =====
`timescale 1ns / 1ps
module lzd_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/multi_mode_lz_decompressor_top.sv =====
`timescale 1ns / 1ps
// a literal or stored byte is registered in the byte stage and then in the output register
// copies: one history read per cycle while the output takes results; bytes leave in pairs, the last may leave alone
// a new input byte is accepted only once the byte stage is empty
// the input waits while a copy runs through the single history read port
// reset: asynchronous, clears parser state and output valid; history content is kept
module multi_mode_lz_decompressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_a, [15:8] byte_b, [17:16] byte_count, [41:18] total_length, rest zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,  // last_of_run
  output logic [1:0]  m_axis_tuser   // [0] stream_done, [1] status
);
  import lzd_pkg::*;

  typedef logic [HIST_AW-1:0] addr_t;

  // parser state
  phase_e      phase_q, phase_d;
  logic [2:0]  mode_q, mode_d;
  logic [15:0] hsize_q, hsize_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  lit_rem_q, lit_rem_d;
  logic [15:0] st_rem_q, st_rem_d;
  logic [7:0]  flags_q, flags_d;
  logic [3:0]  flags_left_q, flags_left_d;
  logic [23:0] pos_q, pos_d;
  addr_t       wptr_q, wptr_d;

  // copy engine
  addr_t       src_q, src_d;
  logic [7:0]  copy_rem_q, copy_rem_d;

  // byte stage after the ram read
  logic        bv_q, bv_d;
  logic        b_byte_q, b_byte_d;
  logic        b_lit_q, b_lit_d;
  logic [7:0]  b_data_q, b_data_d;
  logic        b_last_q, b_last_d;
  logic        b_done_q, b_done_d;
  logic        b_err_q, b_err_d;
  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_data_q, fwd_data_d;

  // pair assembly
  logic        have_a_q, have_a_d;
  logic [7:0]  pa_q, pa_d;

  // output register
  logic        ov_q, ov_d;
  logic [7:0]  o_a_q, o_a_d, o_b_q, o_b_d;
  logic [1:0]  o_cnt_q, o_cnt_d;
  logic        o_last_q, o_last_d, o_done_q, o_done_d, o_err_q, o_err_d;
  logic [23:0] o_len_q, o_len_d;

  logic        in_fire, issue, consume, need_out, out_free;
  logic [7:0]  ram_rdata, bval;
  logic [23:0] pos_inc;
  logic        ram_we;

  assign s_axis_tready = rst_ni && (copy_rem_q == 8'd0) && !bv_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // current byte of the stage
  assign bval     = b_lit_q ? b_data_q : (fwd_q ? fwd_data_q : ram_rdata);
  assign out_free = !ov_q || m_axis_tready;
  assign need_out = !b_byte_q || have_a_q || b_last_q;
  assign consume  = bv_q && (!need_out || out_free);
  assign issue    = (copy_rem_q != 8'd0) && (!bv_q || consume);
  assign ram_we   = consume && b_byte_q;
  assign pos_inc  = (pos_q == LEN_MAX) ? pos_q : pos_q + 24'd1;

  lzd_ram #(
    .DEPTH(HISTORY_DEPTH),
    .WIDTH(8)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wptr_q),
    .wdata_i(bval),
    .re_i   (issue),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  // parser, copy issue, byte stage, pairing and output
  always_comb begin
    logic [15:0] word;
    logic [6:0]  cnt;
    logic [7:0]  lr;
    logic [15:0] sr;
    addr_t       back_dist;

    phase_d = phase_q;  mode_d = mode_q;  hsize_d = hsize_q;
    ctrl_d = ctrl_q;  pend_d = pend_q;  lit_rem_d = lit_rem_q;
    st_rem_d = st_rem_q;  flags_d = flags_q;  flags_left_d = flags_left_q;
    pos_d = pos_q;  wptr_d = wptr_q;  src_d = src_q;  copy_rem_d = copy_rem_q;
    bv_d = bv_q;  b_byte_d = b_byte_q;  b_lit_d = b_lit_q;  b_data_d = b_data_q;
    b_last_d = b_last_q;  b_done_d = b_done_q;  b_err_d = b_err_q;
    fwd_d = fwd_q;  fwd_data_d = fwd_data_q;
    have_a_d = have_a_q;  pa_d = pa_q;
    ov_d = ov_q;  o_a_d = o_a_q;  o_b_d = o_b_q;  o_cnt_d = o_cnt_q;
    o_last_d = o_last_q;  o_done_d = o_done_q;  o_err_d = o_err_q;  o_len_d = o_len_q;
    word = {s_axis_tdata, pend_q};
    cnt = 7'd0;
    lr = 8'd0;
    sr = 16'd0;
    back_dist = '0;

    // output register drains
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    // byte stage consumption
    if (consume) begin
      bv_d  = 1'b0;
      fwd_d = 1'b0;
      if (b_byte_q) begin
        wptr_d = wptr_q + addr_t'(1);
        pos_d  = pos_inc;
        if (have_a_q || b_last_q) begin
          ov_d     = 1'b1;
          o_a_d    = have_a_q ? pa_q : bval;
          o_b_d    = have_a_q ? bval : 8'd0;
          o_cnt_d  = have_a_q ? 2'd2 : 2'd1;
          o_last_d = b_last_q;
          o_done_d = b_done_q;
          o_err_d  = b_err_q;
          o_len_d  = pos_inc;
          have_a_d = 1'b0;
        end else begin
          pa_d     = bval;
          have_a_d = 1'b1;
        end
      end else begin
        ov_d     = 1'b1;
        o_a_d    = 8'd0;
        o_b_d    = 8'd0;
        o_cnt_d  = 2'd0;
        o_last_d = 1'b1;
        o_done_d = b_done_q;
        o_err_d  = b_err_q;
        o_len_d  = pos_q;
      end
    end

    // copy read issue with write forwarding
    if (issue) begin
      bv_d       = 1'b1;
      b_byte_d   = 1'b1;
      b_lit_d    = 1'b0;
      b_last_d   = (copy_rem_q == 8'd1);
      b_done_d   = 1'b0;
      b_err_d    = STATUS_OK;
      fwd_d      = ram_we && (wptr_q == src_q);
      fwd_data_d = bval;
      src_d      = src_q + addr_t'(1);
      copy_rem_d = copy_rem_q - 8'd1;
    end

    // command parsing
    if (in_fire) begin
      b_lit_d  = 1'b1;
      b_data_d = s_axis_tdata;
      b_last_d = 1'b1;
      b_done_d = 1'b0;
      b_err_d  = STATUS_OK;
      b_byte_d = 1'b1;
      fwd_d    = 1'b0;
      unique case (phase_q)
        PH_HDR0: begin
          pos_d   = 24'd0;
          wptr_d  = '0;
          hsize_d = {8'd0, s_axis_tdata};
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          hsize_d = {s_axis_tdata, hsize_q[7:0]};
          phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          pend_d  = s_axis_tdata;
          phase_d = PH_HDR3;
        end
        PH_HDR3: begin
          if (word <= MODE_WORD_MAX && !word[0]) begin
            mode_d = word[3:1];
            if (word[3:1] <= MODE_CTRL11) begin
              phase_d = PH_CTRL;
            end else if (word[3:1] <= MODE_FLAG12) begin
              phase_d = PH_FLAG;
            end else begin
              st_rem_d = hsize_q;
              if (hsize_q == 16'd0) begin
                bv_d = 1'b1;  b_byte_d = 1'b0;  b_done_d = 1'b1;
                phase_d = PH_HDR0;
              end else begin
                phase_d = PH_STORED;
              end
            end
          end else begin
            bv_d = 1'b1;  b_byte_d = 1'b0;  b_done_d = 1'b1;
            b_err_d = STATUS_BAD_MODE;
            phase_d = PH_HDR0;
          end
        end
        PH_CTRL: begin
          if (!s_axis_tdata[7]) begin
            lit_rem_d = {1'b0, s_axis_tdata[6:0]} + 8'd1;
            phase_d   = PH_LIT;
          end else begin
            if (mode_q == MODE_ABS) begin
              cnt = s_axis_tdata[6:0];
            end else if (mode_q == MODE_CTRL10) begin
              cnt = {2'b00, s_axis_tdata[6:2]};
            end else begin
              cnt = {3'b000, s_axis_tdata[6:3]};
            end
            if (cnt == 7'd0) begin
              bv_d = 1'b1;  b_byte_d = 1'b0;  b_done_d = 1'b1;
              phase_d = PH_HDR0;
            end else begin
              ctrl_d  = s_axis_tdata;
              phase_d = (mode_q == MODE_ABS) ? PH_OFS_LO : PH_DIST;
            end
          end
        end
        PH_OFS_LO: begin
          pend_d  = s_axis_tdata;
          phase_d = PH_OFS_HI;
        end
        PH_OFS_HI: begin
          src_d      = word[HIST_AW-1:0];
          copy_rem_d = {1'b0, ctrl_q[6:0]} + 8'd1;
          phase_d    = PH_CTRL;
        end
        PH_DIST: begin
          if (mode_q == MODE_CTRL10) begin
            back_dist  = addr_t'({ctrl_q[1:0], s_axis_tdata});
            copy_rem_d = {3'b000, ctrl_q[6:2]} + 8'd1;
          end else begin
            back_dist  = addr_t'({ctrl_q[2:0], s_axis_tdata});
            copy_rem_d = {4'b0000, ctrl_q[6:3]} + 8'd1;
          end
          src_d   = wptr_q - back_dist;
          phase_d = PH_CTRL;
        end
        PH_LIT: begin
          bv_d = 1'b1;
          lr = (lit_rem_q != 8'd0) ? lit_rem_q - 8'd1 : 8'd0;
          lit_rem_d = lr;
          if (lr == 8'd0) begin
            if (mode_q == MODE_FLAG13 || mode_q == MODE_FLAG12) begin
              flags_d      = {1'b0, flags_q[7:1]};
              flags_left_d = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;
              phase_d      = (flags_left_d != 4'd0) ? PH_ITEM : PH_FLAG;
            end else begin
              phase_d = PH_CTRL;
            end
          end
        end
        PH_FLAG: begin
          flags_d      = s_axis_tdata;
          flags_left_d = 4'd8;
          phase_d      = PH_ITEM;
        end
        PH_ITEM: begin
          if (flags_q[0]) begin
            pend_d  = s_axis_tdata;
            phase_d = PH_PAIR2;
          end else if (s_axis_tdata == 8'd0) begin
            bv_d = 1'b1;  b_byte_d = 1'b0;  b_done_d = 1'b1;
            phase_d = PH_HDR0;
          end else begin
            lit_rem_d = s_axis_tdata;
            phase_d   = PH_LIT;
          end
        end
        PH_PAIR2: begin
          if (mode_q == MODE_FLAG13) begin
            back_dist  = addr_t'({pend_q[2:0], s_axis_tdata});
            copy_rem_d = {3'b000, pend_q[7:3]} + 8'd3;
          end else begin
            back_dist  = addr_t'({pend_q[3:0], s_axis_tdata});
            copy_rem_d = {4'b0000, pend_q[7:4]} + 8'd3;
          end
          src_d        = wptr_q - back_dist;
          flags_d      = {1'b0, flags_q[7:1]};
          flags_left_d = (flags_left_q != 4'd0) ? flags_left_q - 4'd1 : 4'd0;
          phase_d      = (flags_left_d != 4'd0) ? PH_ITEM : PH_FLAG;
        end
        PH_STORED: begin
          bv_d = 1'b1;
          sr = (st_rem_q != 16'd0) ? st_rem_q - 16'd1 : 16'd0;
          st_rem_d = sr;
          if (sr == 16'd0) begin
            b_done_d = 1'b1;
            phase_d  = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      mode_q       <= MODE_ABS;
      hsize_q      <= 16'd0;
      ctrl_q       <= 8'd0;
      pend_q       <= 8'd0;
      lit_rem_q    <= 8'd0;
      st_rem_q     <= 16'd0;
      flags_q      <= 8'd0;
      flags_left_q <= 4'd0;
      pos_q        <= 24'd0;
      wptr_q       <= '0;
      copy_rem_q   <= 8'd0;
      bv_q         <= 1'b0;
      fwd_q        <= 1'b0;
      have_a_q     <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      mode_q       <= mode_d;
      hsize_q      <= hsize_d;
      ctrl_q       <= ctrl_d;
      pend_q       <= pend_d;
      lit_rem_q    <= lit_rem_d;
      st_rem_q     <= st_rem_d;
      flags_q      <= flags_d;
      flags_left_q <= flags_left_d;
      pos_q        <= pos_d;
      wptr_q       <= wptr_d;
      copy_rem_q   <= copy_rem_d;
      bv_q         <= bv_d;
      fwd_q        <= fwd_d;
      have_a_q     <= have_a_d;
      ov_q         <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    b_byte_q   <= b_byte_d;
    b_lit_q    <= b_lit_d;
    b_data_q   <= b_data_d;
    b_last_q   <= b_last_d;
    b_done_q   <= b_done_d;
    b_err_q    <= b_err_d;
    fwd_data_q <= fwd_data_d;
    pa_q       <= pa_d;
    o_a_q      <= o_a_d;
    o_b_q      <= o_b_d;
    o_cnt_q    <= o_cnt_d;
    o_last_q   <= o_last_d;
    o_done_q   <= o_done_d;
    o_err_q    <= o_err_d;
    o_len_q    <= o_len_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, o_len_q, o_cnt_q, o_b_q, o_a_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = {o_err_q, o_done_q};

`ifndef SYNTHESIS
  // forwarded data only exists with a byte waiting in the stage
  a_fwd_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> bv_q) else $error("forward flag without pending byte");

  // an issued read always lands in the byte stage
  a_issue_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> bv_q) else $error("issued read lost");

  // an empty result is only a done result
  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_cnt_q == 2'd0) |-> (o_done_q && o_last_q))
    else $error("empty result without done");

  // bad mode is reported only on an empty done result
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_err_q) |-> (o_cnt_q == 2'd0 && o_done_q))
    else $error("error status on data result");
`endif

endmodule
